/* design/coefficient_quantizer_assert.svh */
// Assertion macros shared by the coefficient quantizer modules.
// No dependencies; included by the files that carry assertions.
`ifndef COEFFICIENT_QUANTIZER_ASSERT_SVH
`define COEFFICIENT_QUANTIZER_ASSERT_SVH

`ifndef NO_ASSERTIONS
`define CQ_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("coefficient_quantizer: assertion failed");
`define CQ_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("coefficient_quantizer: assertion failed");
`else
`define CQ_ASSERT_IMP(label, clk, rstn, ante, cons)
`define CQ_ASSERT_NXT(label, clk, rstn, ante, cons)
`endif

`endif

/* design/cq_pkg.sv */
// Shared constants and codes of the coefficient quantizer.
// No dependencies.
package cq_pkg;

    localparam int STEP_W     = 10;
    localparam int DIM_W      = 7;
    localparam int POS_W      = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_LUMA   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_U      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_V      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_DIM   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_DIM  = 3'd4;

    localparam logic [STEP_W-1:0] STEP_RESET = 10'd8;
    localparam logic [DIM_W-1:0]  DIM_RESET  = 7'd16;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_BAD_ORDER = 2'd1;
    localparam logic [1:0] ST_BEYOND    = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    localparam logic ACT_QUANT   = 1'b0;
    localparam logic ACT_DEQUANT = 1'b1;

    localparam logic [1:0] PLANE_Y = 2'd0;
    localparam logic [1:0] PLANE_U = 2'd1;

    localparam logic [STEP_W-1:0] DC_FLOOR     = 10'd8;
    localparam logic [POS_W-1:0]  DC_GRID_MASK = 6'd3;

endpackage

/* design/cq_front.sv */
// Input stage: region checks, step selection, dividend and product setup.
// Depends on cq_pkg.
module cq_front #(
    parameter int COEFF_BITS = 16,
    parameter int MAX_DIM    = 64,
    parameter int NUM_W      = 18,
    parameter int DIV_W      = 11,
    parameter int PROD_W     = 27
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_action,
    input  logic [1:0]                    s_plane,
    input  logic [cq_pkg::POS_W-1:0]      s_pos_first,
    input  logic [cq_pkg::POS_W-1:0]      s_pos_second,
    input  logic [cq_pkg::POS_W-1:0]      s_region_first_lo,
    input  logic [cq_pkg::POS_W-1:0]      s_region_second_lo,
    input  logic [cq_pkg::POS_W-1:0]      s_region_first_hi,
    input  logic [cq_pkg::POS_W-1:0]      s_region_second_hi,
    input  logic signed [COEFF_BITS-1:0]  s_coeff_in,
    input  logic [cq_pkg::STEP_W-1:0]     step_luma,
    input  logic [cq_pkg::STEP_W-1:0]     step_chroma_u,
    input  logic [cq_pkg::STEP_W-1:0]     step_chroma_v,
    input  logic [cq_pkg::DIM_W-1:0]      luma_first_dim,
    input  logic [cq_pkg::DIM_W-1:0]      luma_second_dim,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          out_action,
    output logic                          out_neg,
    output logic [1:0]                    out_status,
    output logic signed [COEFF_BITS-1:0]  out_coeff,
    output logic signed [PROD_W-1:0]      out_prod,
    output logic [NUM_W-1:0]              out_num,
    output logic [DIV_W-1:0]              out_div
);

    localparam int CLOG_DIM = $clog2(MAX_DIM + 1);
    localparam int CMP_W    = (CLOG_DIM > cq_pkg::DIM_W) ? CLOG_DIM : cq_pkg::DIM_W;
    localparam logic [CMP_W-1:0] MAX_DIM_C = CMP_W'(MAX_DIM);

    logic                            valid_reg;
    logic                            action_reg;
    logic                            neg_reg;
    logic [1:0]                      status_reg;
    logic signed [COEFF_BITS-1:0]    coeff_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic [NUM_W-1:0]                num_reg;
    logic [DIV_W-1:0]                div_reg;

    logic                            chroma;
    logic [CMP_W-1:0]                dim_f, dim_s, size_f, size_s;
    logic                            bad_order, beyond, outside, dc_pos;
    logic [cq_pkg::STEP_W-1:0]       step_sel, step_nz, step_eff;
    logic [COEFF_BITS-1:0]           cu, mag;
    logic [1:0]                      status_next;

    always_comb begin
        chroma = (s_plane != cq_pkg::PLANE_Y);
        dim_f  = CMP_W'(luma_first_dim);
        dim_s  = CMP_W'(luma_second_dim);
        if (dim_f > MAX_DIM_C) begin
            dim_f = MAX_DIM_C;
        end
        if (dim_s > MAX_DIM_C) begin
            dim_s = MAX_DIM_C;
        end
        size_f = chroma ? (dim_f >> 1) : dim_f;
        size_s = chroma ? (dim_s >> 1) : dim_s;

        bad_order = (s_region_first_lo >= s_region_first_hi)
                 || (s_region_second_lo >= s_region_second_hi);
        beyond    = (CMP_W'(s_region_first_hi) >= size_f)
                 || (CMP_W'(s_region_second_hi) >= size_s);
        outside   = (s_pos_first < s_region_first_lo) || (s_pos_first > s_region_first_hi)
                 || (s_pos_second < s_region_second_lo)
                 || (s_pos_second > s_region_second_hi);

        if (bad_order) begin
            status_next = cq_pkg::ST_BAD_ORDER;
        end else if (beyond) begin
            status_next = cq_pkg::ST_BEYOND;
        end else if (outside) begin
            status_next = cq_pkg::ST_OUTSIDE;
        end else begin
            status_next = cq_pkg::ST_DONE;
        end

        if (s_plane == cq_pkg::PLANE_Y) begin
            step_sel = step_luma;
        end else if (s_plane == cq_pkg::PLANE_U) begin
            step_sel = step_chroma_u;
        end else begin
            step_sel = step_chroma_v;
        end
        step_nz  = (step_sel == '0) ? cq_pkg::STEP_W'(1) : step_sel;
        dc_pos   = ((s_pos_first & cq_pkg::DC_GRID_MASK) == '0)
                && ((s_pos_second & cq_pkg::DC_GRID_MASK) == '0);
        step_eff = (dc_pos && (step_nz < cq_pkg::DC_FLOOR)) ? cq_pkg::DC_FLOOR : step_nz;

        cu  = s_coeff_in;
        mag = cu[COEFF_BITS-1] ? (~cu + {{(COEFF_BITS-1){1'b0}}, 1'b1}) : cu;
    end

    assign s_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            action_reg <= s_action;
            neg_reg    <= s_coeff_in[COEFF_BITS-1];
            status_reg <= status_next;
            coeff_reg  <= s_coeff_in;
            prod_reg   <= PROD_W'(s_coeff_in) * PROD_W'($signed({1'b0, step_eff}));
            num_reg    <= NUM_W'({mag, 1'b0}) + NUM_W'(step_eff);
            div_reg    <= DIV_W'({step_eff, 1'b0});
        end
    end

    assign out_valid  = valid_reg;
    assign out_action = action_reg;
    assign out_neg    = neg_reg;
    assign out_status = status_reg;
    assign out_coeff  = coeff_reg;
    assign out_prod   = prod_reg;
    assign out_num    = num_reg;
    assign out_div    = div_reg;

endmodule

/* design/cq_div_cell.sv */
// One restoring-division cell: retires one quotient bit per item per cycle unless out_ready stalls it.
// Depends on coefficient_quantizer_assert.svh.
`include "coefficient_quantizer_assert.svh"

module cq_div_cell #(
    parameter int REM_W  = 11,
    parameter int NUM_W  = 18,
    parameter int SIDE_W = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [REM_W-1:0]  in_rem,
    input  logic [NUM_W-1:0]  in_nq,
    input  logic [REM_W-1:0]  in_div,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [REM_W-1:0]  out_rem,
    output logic [NUM_W-1:0]  out_nq,
    output logic [REM_W-1:0]  out_div,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [NUM_W-1:0]  nq_reg;
    logic [REM_W-1:0]  div_reg;
    logic [SIDE_W-1:0] side_reg;

    logic [REM_W:0]    trial;
    logic [REM_W:0]    diff;
    logic              take;
    logic [REM_W-1:0]  rem_next;
    logic [NUM_W-1:0]  nq_next;

    always_comb begin
        trial    = {in_rem, in_nq[NUM_W-1]};
        diff     = trial - {1'b0, in_div};
        take     = (trial >= {1'b0, in_div});
        rem_next = take ? diff[REM_W-1:0] : trial[REM_W-1:0];
        nq_next  = {in_nq[NUM_W-2:0], take};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            rem_reg  <= rem_next;
            nq_reg   <= nq_next;
            div_reg  <= in_div;
            side_reg <= in_side;
        end
    end

    assign out_valid = valid_reg;
    assign out_rem   = rem_reg;
    assign out_nq    = nq_reg;
    assign out_div   = div_reg;
    assign out_side  = side_reg;

    `CQ_ASSERT_IMP(a_rem_below_div, aclk, aresetn, valid_reg, rem_reg < div_reg)
    `CQ_ASSERT_NXT(a_word_advances, aclk, aresetn, in_valid && in_ready, valid_reg)

endmodule

/* design/cq_back.sv */
// Output stage: sign, saturation and result select into the output register.
// Depends on cq_pkg and coefficient_quantizer_assert.svh.
`include "coefficient_quantizer_assert.svh"

module cq_back #(
    parameter int COEFF_BITS = 16,
    parameter int NUM_W      = 18,
    parameter int PROD_W     = 27
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_action,
    input  logic                          in_neg,
    input  logic [1:0]                    in_status,
    input  logic signed [COEFF_BITS-1:0]  in_coeff,
    input  logic signed [PROD_W-1:0]      in_prod,
    input  logic [NUM_W-1:0]              in_quot,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COEFF_BITS-1:0]  m_coeff_out,
    output logic [1:0]                    m_status
);

    localparam logic signed [COEFF_BITS-1:0] C_HI = {1'b0, {(COEFF_BITS-1){1'b1}}};
    localparam logic signed [COEFF_BITS-1:0] C_LO = {1'b1, {(COEFF_BITS-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] P_HI =
        {{(PROD_W-COEFF_BITS+1){1'b0}}, {(COEFF_BITS-1){1'b1}}};
    localparam logic signed [PROD_W-1:0] P_LO =
        {{(PROD_W-COEFF_BITS+1){1'b1}}, {(COEFF_BITS-1){1'b0}}};
    localparam logic [NUM_W-1:0] Q_POS_LIM =
        {{(NUM_W-COEFF_BITS+1){1'b0}}, {(COEFF_BITS-1){1'b1}}};
    localparam logic [NUM_W-1:0] Q_NEG_LIM =
        {{(NUM_W-COEFF_BITS){1'b0}}, 1'b1, {(COEFF_BITS-1){1'b0}}};

    logic                          valid_reg;
    logic signed [COEFF_BITS-1:0]  coeff_reg;
    logic [1:0]                    status_reg;

    logic [NUM_W-1:0]              quot_neg;
    logic signed [COEFF_BITS-1:0]  q_res, p_res, coeff_next;
    logic                          status_rej;

    always_comb begin
        quot_neg = '0 - in_quot;
        if (in_neg) begin
            q_res = (in_quot > Q_NEG_LIM) ? C_LO : quot_neg[COEFF_BITS-1:0];
        end else begin
            q_res = (in_quot > Q_POS_LIM) ? C_HI : in_quot[COEFF_BITS-1:0];
        end

        if (in_prod > P_HI) begin
            p_res = C_HI;
        end else if (in_prod < P_LO) begin
            p_res = C_LO;
        end else begin
            p_res = in_prod[COEFF_BITS-1:0];
        end

        case (in_status)
            cq_pkg::ST_DONE: begin
                coeff_next = (in_action == cq_pkg::ACT_DEQUANT) ? p_res : q_res;
            end
            cq_pkg::ST_OUTSIDE: begin
                coeff_next = in_coeff;
            end
            default: begin
                coeff_next = '0;
            end
        endcase
    end

    assign in_ready = !valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_valid && in_ready) begin
            coeff_reg  <= coeff_next;
            status_reg <= in_status;
        end
    end

    assign m_valid     = valid_reg;
    assign m_coeff_out = coeff_reg;
    assign m_status    = status_reg;

    assign status_rej = (status_reg == cq_pkg::ST_BAD_ORDER) || (status_reg == cq_pkg::ST_BEYOND);

    `CQ_ASSERT_IMP(a_error_zero, aclk, aresetn, valid_reg && status_rej, coeff_reg == '0)

endmodule

/* design/coefficient_quantizer.sv */
// Channel  | Handshake              | Payload
// s_       | s_valid / s_ready      | action, plane, position, region bounds, coeff_in
// m_       | m_valid / m_ready      | coeff_out, status
// cfg_     | cfg_valid / cfg_ready  | cfg_index, cfg_data (cfg_ready always high)
//
// One word per cycle sustained while m_ready holds; registers in order: input stage, one
// division cell per quotient bit (NUM_W = max(COEFF_BITS+1, 10) + 1), output register.
// The divider cell row sets the latency; the multiplier sits in the input stage.
// Reset clears only valid bits and loads the step and size registers; no clearing pass.
// A stall on m_ready reaches back through the cells over a combinational ready chain; bubbles collapse.
// Top level of the coefficient quantizer; depends on cq_pkg, cq_front, cq_div_cell, cq_back.
`include "coefficient_quantizer_assert.svh"

module coefficient_quantizer #(
    parameter int COEFF_BITS = 16,
    parameter int MAX_DIM    = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [1:0]                        s_plane,
    input  logic [cq_pkg::POS_W-1:0]          s_pos_first,
    input  logic [cq_pkg::POS_W-1:0]          s_pos_second,
    input  logic [cq_pkg::POS_W-1:0]          s_region_first_lo,
    input  logic [cq_pkg::POS_W-1:0]          s_region_second_lo,
    input  logic [cq_pkg::POS_W-1:0]          s_region_first_hi,
    input  logic [cq_pkg::POS_W-1:0]          s_region_second_hi,
    input  logic signed [COEFF_BITS-1:0]      s_coeff_in,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [COEFF_BITS-1:0]      m_coeff_out,
    output logic [1:0]                        m_status,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [cq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [cq_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int NUM_BASE = (COEFF_BITS + 1 > cq_pkg::STEP_W)
                            ? COEFF_BITS + 1 : cq_pkg::STEP_W;
    localparam int NUM_W    = NUM_BASE + 1;
    localparam int DIV_W    = cq_pkg::STEP_W + 1;
    localparam int PROD_W   = COEFF_BITS + cq_pkg::STEP_W + 1;
    localparam int SIDE_W   = 4 + COEFF_BITS + PROD_W;

    logic [cq_pkg::STEP_W-1:0] step_luma_reg, step_u_reg, step_v_reg;
    logic [cq_pkg::DIM_W-1:0]  first_dim_reg, second_dim_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_luma_reg  <= cq_pkg::STEP_RESET;
            step_u_reg     <= cq_pkg::STEP_RESET;
            step_v_reg     <= cq_pkg::STEP_RESET;
            first_dim_reg  <= cq_pkg::DIM_RESET;
            second_dim_reg <= cq_pkg::DIM_RESET;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                cq_pkg::REG_STEP_LUMA:  step_luma_reg  <= cfg_data;
                cq_pkg::REG_STEP_U:     step_u_reg     <= cfg_data;
                cq_pkg::REG_STEP_V:     step_v_reg     <= cfg_data;
                cq_pkg::REG_FIRST_DIM:  first_dim_reg  <= cfg_data[cq_pkg::DIM_W-1:0];
                cq_pkg::REG_SECOND_DIM: second_dim_reg <= cfg_data[cq_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic                          f_action, f_neg;
    logic [1:0]                    f_status;
    logic signed [COEFF_BITS-1:0]  f_coeff;
    logic signed [PROD_W-1:0]      f_prod;

    logic              stg_valid [0:NUM_W];
    logic              stg_ready [0:NUM_W];
    logic [DIV_W-1:0]  stg_rem   [0:NUM_W];
    logic [NUM_W-1:0]  stg_nq    [0:NUM_W];
    logic [DIV_W-1:0]  stg_div   [0:NUM_W];
    logic [SIDE_W-1:0] stg_side  [0:NUM_W];

    cq_front #(
        .COEFF_BITS (COEFF_BITS),
        .MAX_DIM    (MAX_DIM),
        .NUM_W      (NUM_W),
        .DIV_W      (DIV_W),
        .PROD_W     (PROD_W)
    ) u_front (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_plane            (s_plane),
        .s_pos_first        (s_pos_first),
        .s_pos_second       (s_pos_second),
        .s_region_first_lo  (s_region_first_lo),
        .s_region_second_lo (s_region_second_lo),
        .s_region_first_hi  (s_region_first_hi),
        .s_region_second_hi (s_region_second_hi),
        .s_coeff_in         (s_coeff_in),
        .step_luma          (step_luma_reg),
        .step_chroma_u      (step_u_reg),
        .step_chroma_v      (step_v_reg),
        .luma_first_dim     (first_dim_reg),
        .luma_second_dim    (second_dim_reg),
        .out_valid          (stg_valid[0]),
        .out_ready          (stg_ready[0]),
        .out_action         (f_action),
        .out_neg            (f_neg),
        .out_status         (f_status),
        .out_coeff          (f_coeff),
        .out_prod           (f_prod),
        .out_num            (stg_nq[0]),
        .out_div            (stg_div[0])
    );

    assign stg_rem[0]  = '0;
    assign stg_side[0] = {f_action, f_neg, f_status, f_coeff, f_prod};

    for (genvar i = 0; i < NUM_W; i++) begin : g_cell
        cq_div_cell #(
            .REM_W  (DIV_W),
            .NUM_W  (NUM_W),
            .SIDE_W (SIDE_W)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_rem    (stg_rem[i]),
            .in_nq     (stg_nq[i]),
            .in_div    (stg_div[i]),
            .in_side   (stg_side[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_rem   (stg_rem[i+1]),
            .out_nq    (stg_nq[i+1]),
            .out_div   (stg_div[i+1]),
            .out_side  (stg_side[i+1])
        );
    end

    logic [SIDE_W-1:0] side_end;
    assign side_end = stg_side[NUM_W];

    cq_back #(
        .COEFF_BITS (COEFF_BITS),
        .NUM_W      (NUM_W),
        .PROD_W     (PROD_W)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (stg_valid[NUM_W]),
        .in_ready    (stg_ready[NUM_W]),
        .in_action   (side_end[PROD_W+COEFF_BITS+3]),
        .in_neg      (side_end[PROD_W+COEFF_BITS+2]),
        .in_status   (side_end[PROD_W+COEFF_BITS +: 2]),
        .in_coeff    ($signed(side_end[PROD_W +: COEFF_BITS])),
        .in_prod     ($signed(side_end[PROD_W-1:0])),
        .in_quot     (stg_nq[NUM_W]),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_coeff_out (m_coeff_out),
        .m_status    (m_status)
    );

    `CQ_ASSERT_IMP(a_stall_from_output, aclk, aresetn, !s_ready, m_valid && !m_ready)

endmodule
